// ===== rtl/adpcm_block_decoder_assert.svh =====
// Assertion macros for the ADPCM block decoder.
// Uses the clk_i / rst_ni names of the module that includes it.
`ifndef ADPCM_BLOCK_DECODER_ASSERT_SVH
`define ADPCM_BLOCK_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ABD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ABD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/adpcm_blk_pkg.sv =====
// Shared types, constants and coefficient lookup for the ADPCM block decoder.
// No dependencies.
package adpcm_blk_pkg;

  localparam int unsigned FilterCount = 5;
  localparam logic [7:0]  MuteFlag    = 8'h07;
  localparam logic [3:0]  PosHeader   = 4'd0;
  localparam logic [3:0]  PosFlag     = 4'd1;
  localparam logic [3:0]  PosLast     = 4'd15;
  localparam int unsigned CodeShift   = 12;
  localparam int unsigned PredShift   = 6;   // divide by 64
  localparam logic signed [15:0] ClipMax = 16'sh7FFF;
  localparam logic signed [15:0] ClipMin = 16'sh8000;

  // Per-block decode settings from the header and flag bytes.
  typedef struct packed {
    logic [2:0] filter;
    logic [3:0] shift;
    logic       mute;
  } blk_cfg_t;

  // What an accepted byte asks of the work stage.
  typedef struct packed {
    logic load_data;  // data byte: two samples
    logic load_err;   // bad header: one error transaction
    logic last;       // final data byte of the block
  } blk_act_t;

  function automatic logic signed [7:0] coef_h1(input logic [2:0] f);
    logic signed [7:0] c;
    case (f)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [7:0] coef_h2(input logic [2:0] f);
    logic signed [7:0] c;
    case (f)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/adpcm_block_decoder.sv =====
// ADPCM block decoder, top level: work stage and result register.
// Depends on adpcm_blk_pkg, adpcm_blk_hdr, adpcm_blk_core and the assert macros.
//
// - Input channel (in_valid_i / in_stall_o / data_byte_i): byte stream in
//   16-byte blocks: header (filter, shift), flag, 14 data bytes.
// - Output channel (out_valid_o / out_stall_i): one sample per transaction
//   with block_last_o and bad_filter_o.
// - Header and flag bytes give no output; a data byte gives two samples, low
//   nibble first. A header with filter 5 or more gives one error transaction
//   (sample 0, last and bad set) and the rest of its block is swallowed.
// - Flow: a data byte is loaded into the work stage, then each sample into the
//   result register. A data byte holds the work stage until both samples are
//   out, since the second sample's prediction needs the first; a bad header
//   holds it for its error transaction; flag, good header and dropped bytes
//   never enter it. A new byte is taken in the cycle the work stage finishes.
// - Receiver stall: the result register holds; a byte in the work stage waits
//   and keeps in_stall_o high until the held result is taken.
// - Reset clears history, block position and all valid flags.
module adpcm_block_decoder
  import adpcm_blk_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] pcm_sample_o,
  output logic               block_last_o,
  output logic               bad_filter_o
);

`include "adpcm_block_decoder_assert.svh"

  blk_cfg_t blk_cfg;
  blk_act_t blk_act;

  // work stage: one data byte (two samples) or one error transaction
  logic       work_valid_q, work_valid_d;
  logic       work_err_q, work_err_d;
  logic       work_phase_q, work_phase_d;  // 1: high nibble pending
  logic       work_last_q, work_last_d;
  logic [7:0] work_byte_q, work_byte_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] out_pcm_q, out_pcm_d;
  logic               out_last_q, out_last_d;
  logic               out_bad_q, out_bad_d;

  logic               out_free, emit, work_done, work_free, in_acc;
  logic [3:0]         nibble;
  logic signed [15:0] sample;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = work_valid_q && out_free;
  assign work_done = emit && (work_phase_q || work_err_q);
  assign work_free = !work_valid_q || work_done;
  assign in_stall_o = !work_free;
  assign in_acc    = in_valid_i && work_free;

  assign nibble = work_phase_q ? work_byte_q[7:4] : work_byte_q[3:0];

  adpcm_blk_hdr u_hdr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .data_byte_i (data_byte_i),
    .cfg_o       (blk_cfg),
    .act_o       (blk_act)
  );

  adpcm_blk_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (blk_cfg),
    .nibble_i (nibble),
    .step_i   (emit && !work_err_q),
    .sample_o (sample)
  );

  always_comb begin
    work_valid_d = work_valid_q;
    work_err_d   = work_err_q;
    work_phase_d = work_phase_q;
    work_last_d  = work_last_q;
    work_byte_d  = work_byte_q;
    if (blk_act.load_data || blk_act.load_err) begin
      work_valid_d = 1'b1;
      work_err_d   = blk_act.load_err;
      work_phase_d = 1'b0;
      work_last_d  = blk_act.last;
      work_byte_d  = data_byte_i;
    end else if (work_done) begin
      work_valid_d = 1'b0;
    end else if (emit) begin
      work_phase_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_pcm_d   = out_pcm_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_pcm_d   = work_err_q ? 16'sd0 : sample;
      out_last_d  = work_err_q || (work_phase_q && work_last_q);
      out_bad_d   = work_err_q;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      work_err_q   <= 1'b0;
      work_phase_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      work_valid_q <= work_valid_d;
      work_err_q   <= work_err_d;
      work_phase_q <= work_phase_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_last_q <= work_last_d;
    work_byte_q <= work_byte_d;
    out_pcm_q   <= out_pcm_d;
    out_last_q  <= out_last_d;
    out_bad_q   <= out_bad_d;
  end

  assign out_valid_o  = out_valid_q;
  assign pcm_sample_o = out_pcm_q;
  assign block_last_o = out_last_q;
  assign bad_filter_o = out_bad_q;

  `ABD_ASSERT_NOW(a_err_result, out_valid_o && bad_filter_o,
                  block_last_o && (pcm_sample_o == 16'sd0), "error result malformed")
  `ABD_ASSERT_NOW(a_err_one_phase, work_valid_q && work_err_q, !work_phase_q,
                  "error transaction reached second phase")
  `ABD_ASSERT_NXT(a_work_hold, work_valid_q && !out_free,
                  work_valid_q && $stable(work_phase_q), "work stage moved under stall")

endmodule

// ===== rtl/adpcm_blk_hdr.sv =====
// Block framing: byte position, header and flag parsing, drop handling.
// Depends on adpcm_blk_pkg.
module adpcm_blk_hdr
  import adpcm_blk_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  output blk_cfg_t   cfg_o,
  output blk_act_t   act_o
);

  logic [3:0] pos_q, pos_d;
  blk_cfg_t   cfg_q, cfg_d;
  logic       drop_q, drop_d;
  logic       bad_hdr;

  assign bad_hdr = data_byte_i[7:4] >= 4'(FilterCount);

  always_comb begin
    pos_d  = pos_q;
    cfg_d  = cfg_q;
    drop_d = drop_q;
    act_o  = '0;
    if (accept_i) begin
      pos_d = pos_q + 4'd1;
      if (pos_q == PosHeader) begin
        cfg_d.mute = 1'b0;
        if (bad_hdr) begin
          drop_d         = 1'b1;
          act_o.load_err = 1'b1;
        end else begin
          drop_d       = 1'b0;
          cfg_d.filter = data_byte_i[6:4];
          cfg_d.shift  = data_byte_i[3:0];
        end
      end else if (!drop_q) begin
        if (pos_q == PosFlag) begin
          cfg_d.mute = data_byte_i >= MuteFlag;
        end else begin
          act_o.load_data = 1'b1;
          act_o.last      = pos_q == PosLast;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= PosHeader;
      cfg_q  <= '0;
      drop_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      cfg_q  <= cfg_d;
      drop_q <= drop_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/adpcm_blk_core.sv =====
// Sample datapath: code scaling, two-tap prediction, clipping, history.
// Depends on adpcm_blk_pkg.
module adpcm_blk_core
  import adpcm_blk_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  blk_cfg_t           cfg_i,
  input  logic [3:0]         nibble_i,
  input  logic               step_i,
  output logic signed [15:0] sample_o
);

  logic signed [15:0] h1_q, h2_q;
  logic signed [3:0]  code;
  logic signed [15:0] scaled, shifted;
  logic signed [7:0]  c0, c1;
  logic signed [23:0] p0, p1;
  logic signed [24:0] psum, padj, pshr;
  logic signed [18:0] pdiv;
  logic signed [19:0] total;
  logic signed [15:0] clipped;

  assign code    = nibble_i;
  assign scaled  = {code, {CodeShift{1'b0}}};
  assign shifted = scaled >>> cfg_i.shift;

  assign c0   = coef_h1(cfg_i.filter);
  assign c1   = coef_h2(cfg_i.filter);
  assign p0   = 24'(h1_q) * 24'(c0);
  assign p1   = 24'(h2_q) * 24'(c1);
  assign psum = {p0[23], p0} + {p1[23], p1};
  // truncate toward zero: bias negative sums before the shift
  assign padj = psum + (psum[24] ? 25'sd63 : 25'sd0);
  assign pshr = padj >>> PredShift;
  assign pdiv = pshr[18:0];

  assign total = {{4{shifted[15]}}, shifted} + {pdiv[18], pdiv};

  always_comb begin
    if (total > 20'(ClipMax)) begin
      clipped = ClipMax;
    end else if (total < 20'(ClipMin)) begin
      clipped = ClipMin;
    end else begin
      clipped = total[15:0];
    end
  end

  assign sample_o = cfg_i.mute ? 16'sd0 : clipped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_q <= '0;
      h2_q <= '0;
    end else if (step_i) begin
      h2_q <= h1_q;
      h1_q <= sample_o;
    end
  end

endmodule
